// ===== rtl/core/dcrf_pkg.sv =====
package dcrf_pkg;

  localparam int DATA_W     = 8;
  localparam int BUS_ADDR_W = 16;
  localparam int SLOT_W     = 4;
  localparam int SLOTS      = 16;
  localparam int MAX_CHANNELS = 8;

  localparam logic [15:0] REG_MASK         = 16'hff8f;
  localparam logic [15:0] REG_BASE         = 16'h4300;
  localparam logic [15:0] REG_SPARE        = 16'h430b;
  localparam logic [15:0] REG_SPARE_MIRROR = 16'h430f;
  localparam logic [15:0] ADDR_DMAEN       = 16'h420b;
  localparam logic [15:0] ADDR_HDMAEN      = 16'h420c;

  localparam logic [SLOT_W-1:0] SLOT_SPARE = REG_SPARE[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] SLOT_LAST  = REG_SPARE[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] SLOT_MIRROR = REG_SPARE_MIRROR[SLOT_W-1:0];

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic              is_write;
    logic              hit_dmaen;
    logic              hit_hdmaen;
    logic              chan_hit;
    logic [2:0]        chan;
    logic [SLOT_W-1:0] slot;
  } dec_t;

endpackage

// ===== rtl/core/dcrf_if.sv =====
interface dcrf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, action, address, data, input ready);
  modport sink (input valid, action, address, data, output ready);
endinterface

interface dcrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] dma_enable_mask;
  logic [7:0] hdma_enable_mask;
  logic       dma_pending;

  modport source (output valid, read_data, dma_enable_mask, hdma_enable_mask, dma_pending,
                  input ready);
  modport sink (input valid, read_data, dma_enable_mask, hdma_enable_mask, dma_pending,
                output ready);
endinterface

// ===== rtl/core/dma_channel_register_file.sv =====
// result: registered, valid in the cycle after its bus word is accepted
// throughput: one word per cycle unless the output stalls, set by the single-port channel byte memory
// the enable masks and pending flag shown are those after the access
// reset: synchronous active-low, clears enables, pending, output valid and
// the per-entry valid bits so every channel register reads zero
module dma_channel_register_file #(
  parameter int CHANNELS = dcrf_pkg::MAX_CHANNELS
) (
  input  logic      clk,
  input  logic      rst_n,
  dcrf_in_if.sink   in_chan,
  dcrf_out_if.source out_chan
);
  import dcrf_pkg::*;

  localparam int DEPTH = CHANNELS * SLOTS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [7:0] CHAN_MASK = 8'((16'd1 << CHANNELS) - 16'd1);

  dec_t             dec;
  logic             accept;
  logic [IDX_W-1:0] mem_idx;
  logic [7:0]       mem_rdata;

  logic       out_valid_r, out_valid_nxt;
  logic       mem_sel_r;
  logic [7:0] data_r;
  logic [7:0] dmaen_r, dmaen_nxt;
  logic [7:0] hdmaen_r, hdmaen_nxt;
  logic       pending_r, pending_nxt;

  dcrf_decode #(
    .CHANNELS (CHANNELS)
  ) u_decode (
    .action  (in_chan.action),
    .address (in_chan.address),
    .dec     (dec)
  );

  assign mem_idx = IDX_W'({dec.chan, dec.slot});

  dcrf_chan_mem #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH),
    .IDX_W    (IDX_W)
  ) u_chan_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (accept && !dec.is_write),
    .wr_en (accept && dec.is_write && !dec.hit_dmaen && !dec.hit_hdmaen && dec.chan_hit),
    .idx   (mem_idx),
    .wdata (in_chan.data),
    .rdata (mem_rdata)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    dmaen_nxt     = dmaen_r;
    hdmaen_nxt    = hdmaen_r;
    pending_nxt   = pending_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (dec.is_write && dec.hit_dmaen) begin
        dmaen_nxt = in_chan.data & CHAN_MASK;
        if (in_chan.data != 8'd0) begin
          pending_nxt = 1'b1;
        end
      end
      if (dec.is_write && dec.hit_hdmaen) begin
        hdmaen_nxt = in_chan.data & CHAN_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dmaen_r     <= '0;
      hdmaen_r    <= '0;
      pending_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      dmaen_r     <= dmaen_nxt;
      hdmaen_r    <= hdmaen_nxt;
      pending_r   <= pending_nxt;
    end
  end

  // unmapped reads return the open-bus value, writes return zero
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_sel_r <= !dec.is_write && dec.chan_hit;
      data_r    <= dec.is_write ? 8'd0 : in_chan.data;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.read_data        = mem_sel_r ? mem_rdata : data_r;
  assign out_chan.dma_enable_mask  = dmaen_r;
  assign out_chan.hdma_enable_mask = hdmaen_r;
  assign out_chan.dma_pending      = pending_r;
endmodule

// ===== rtl/core/dcrf_decode.sv =====
module dcrf_decode #(
  parameter int CHANNELS = 8
) (
  input  logic                 action,
  input  logic [15:0]          address,
  output dcrf_pkg::dec_t       dec
);
  import dcrf_pkg::*;

  logic [15:0] reg_addr;
  logic        reg_hit;
  logic        chan_ok;

  assign reg_addr = address & REG_MASK;
  assign reg_hit  = (reg_addr[15:SLOT_W] == REG_BASE[15:SLOT_W]) &&
                    ((reg_addr[SLOT_W-1:0] <= SLOT_LAST) ||
                     (reg_addr[SLOT_W-1:0] == SLOT_MIRROR));
  assign chan_ok  = {1'b0, address[6:4]} < 4'(CHANNELS);

  always_comb begin
    dec.is_write   = (action == ACT_WRITE);
    dec.hit_dmaen  = (address == ADDR_DMAEN);
    dec.hit_hdmaen = (address == ADDR_HDMAEN);
    dec.chan_hit   = reg_hit && chan_ok;
    dec.chan       = address[6:4];
    // mirror offset folds onto the spare byte
    dec.slot       = (reg_addr[SLOT_W-1:0] == SLOT_MIRROR) ? SLOT_SPARE
                                                            : reg_addr[SLOT_W-1:0];
  end
endmodule

// ===== rtl/core/dcrf_chan_mem.sv =====
module dcrf_chan_mem #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = CHANNELS * dcrf_pkg::SLOTS,
  parameter int IDX_W    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] idx,
  input  logic [7:0]       wdata,
  output logic [7:0]       rdata
);
  import dcrf_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rd_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wdata;
    end
    if (rd_en) begin
      rd_r <= mem[idx];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[idx];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import dcrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_CH = MAX_CHANNELS;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] dma_mask;
    logic [7:0] hdma_mask;
    logic       pending;
  } bus_result_t;

  class regbank_scoreboard;
    logic [7:0]  chan_regs [N_CH][SLOTS];
    logic [7:0]  dma_en;
    logic [7:0]  hdma_en;
    logic        pend_flag;
    bus_result_t awaited_results[$];
    int          errors;

    function new();
      for (int c = 0; c < N_CH; c++) begin
        for (int s = 0; s < SLOTS; s++) begin
          chan_regs[c][s] = 8'h00;
        end
      end
      dma_en = 8'h00;
      hdma_en = 8'h00;
      pend_flag = 1'b0;
      errors = 0;
    endfunction

    function bus_result_t model_access(logic act, logic [15:0] a, logic [7:0] d);
      bus_result_t r;
      logic [2:0]  ch;
      logic [3:0]  slot;
      logic [7:0]  chan_mask;
      logic        mapped;
      ch = a[6:4];
      slot = a[3:0];
      chan_mask = 8'((1 << N_CH) - 1);
      mapped = ((a & REG_MASK & 16'hfff0) == REG_BASE) && (int'(ch) < N_CH) &&
               (slot <= SLOT_LAST || slot == SLOT_MIRROR);
      if (slot == SLOT_MIRROR) begin
        slot = SLOT_SPARE;
      end
      r.read_data = 8'h00;
      if (act == ACT_WRITE) begin
        if (a == ADDR_DMAEN) begin
          dma_en = d & chan_mask;
          if (d != 8'h00) begin
            pend_flag = 1'b1;
          end
        end else if (a == ADDR_HDMAEN) begin
          hdma_en = d & chan_mask;
        end else if (mapped) begin
          chan_regs[ch][slot] = d;
        end
      end else begin
        r.read_data = mapped ? chan_regs[ch][slot] : d;
      end
      r.dma_mask = dma_en;
      r.hdma_mask = hdma_en;
      r.pending = pend_flag;
      return r;
    endfunction

    function void note_access(logic act, logic [15:0] a, logic [7:0] d);
      awaited_results.push_back(model_access(act, a, d));
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t mismatch on %s: got %02h want %02h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [7:0] rd, logic [7:0] dm, logic [7:0] hm, logic pnd);
      bus_result_t w;
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result word", $time);
        errors++;
      end else begin
        w = awaited_results.pop_front();
        if (rd !== w.read_data) report_mismatch("read_data", rd, w.read_data);
        if (dm !== w.dma_mask) report_mismatch("dma_enable_mask", dm, w.dma_mask);
        if (hm !== w.hdma_mask) report_mismatch("hdma_enable_mask", hm, w.hdma_mask);
        if (pnd !== w.pending) report_mismatch("dma_pending", 8'(pnd), 8'(w.pending));
      end
    endtask

    function int awaited();
      return awaited_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_count;

  regbank_scoreboard sb = new();

  dcrf_in_if  in_bus ();
  dcrf_out_if out_bus ();

  dma_channel_register_file u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_access(in_bus.action, in_bus.address, in_bus.data);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.read_data, out_bus.dma_enable_mask,
                        out_bus.hdma_enable_mask, out_bus.dma_pending);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dma_channel_register_file] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic act, logic [15:0] a, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.action = act;
    in_bus.address = a;
    in_bus.data = d;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (sb.awaited() != 0) @(negedge clk);
  endtask

  task automatic directed_words();
    send_word(ACT_READ, 16'h4300, 8'hff);
    send_word(ACT_READ, 16'h437b, 8'haa);
    send_word(ACT_WRITE, 16'h4300, 8'hff);
    send_word(ACT_READ, 16'h4300, 8'h00);
    // spare byte through its mirror offset
    send_word(ACT_WRITE, 16'h437f, 8'h5a);
    send_word(ACT_READ, 16'h437b, 8'h00);
    send_word(ACT_WRITE, 16'h4373, 8'h00);
    send_word(ACT_READ, 16'h4373, 8'hff);
    send_word(ACT_READ, ADDR_DMAEN, 8'h3c);
    send_word(ACT_READ, ADDR_HDMAEN, 8'hc3);
    // zero enable write leaves pending clear
    send_word(ACT_WRITE, ADDR_DMAEN, 8'h00);
    send_word(ACT_WRITE, ADDR_HDMAEN, 8'hff);
    send_word(ACT_WRITE, ADDR_DMAEN, 8'h81);
    send_word(ACT_WRITE, ADDR_DMAEN, 8'h00);
    send_word(ACT_READ, 16'h430c, 8'h11);
    send_word(ACT_WRITE, 16'h435d, 8'h77);
    send_word(ACT_READ, 16'h435d, 8'h22);
    send_word(ACT_READ, 16'h000e, 8'h00);
    send_word(ACT_READ, 16'hffff, 8'hff);
    send_word(ACT_WRITE, 16'hffff, 8'hff);
    send_word(ACT_WRITE, 16'h0000, 8'h00);
    send_word(ACT_READ, 16'h4380, 8'h99);
    send_word(ACT_WRITE, 16'h4392, 8'h12);
    send_word(ACT_READ, 16'h4312, 8'h34);
  endtask

  task automatic random_words(int n);
    int          k;
    logic        act;
    logic [15:0] a;
    logic [7:0]  d;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      act = 1'($urandom_range(1));
      d = 8'($urandom_range(255));
      if (k < 65) begin
        a = REG_BASE | 16'($urandom_range(7) << 4) | 16'($urandom_range(15));
      end else if (k < 80) begin
        a = $urandom_range(1) ? ADDR_DMAEN : ADDR_HDMAEN;
        if ($urandom_range(3) == 0) d = 8'h00;
      end else begin
        a = 16'($urandom_range(16'hffff));
      end
      send_word(act, a, d);
    end
  endtask

  initial begin
    cycle_count = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_READ;
    in_bus.address = 16'h0000;
    in_bus.data = 8'h00;
    out_bus.ready = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 52;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed_words();
    wait_drained();
    random_words(470);
    wait_drained();
    send_idle_pct = 52;
    recv_idle_pct = 31;
    random_words(470);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(470);
    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.awaited() == 0) begin
      $display("[dma_channel_register_file] OK");
    end else begin
      $display("[dma_channel_register_file] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dcrf_pkg.sv
rtl/core/dcrf_if.sv
rtl/core/dcrf_decode.sv
rtl/core/dcrf_chan_mem.sv
rtl/core/dma_channel_register_file.sv
dv/tb_top.sv
